>>> design/lomu_pkg.sv
`timescale 1ns / 1ps

package lomu_pkg;

   // Payload widths
   localparam int RANGE_W = 16;
   localparam int IDX_W   = 10;
   localparam int MID_W   = 17;
   localparam int COUNT_W = 10;
   localparam int ANGLE_W = 16;
   localparam int PROD_W  = 32;

   // Scan length; indexes are taken modulo this
   localparam int SCAN_POINTS = 1024;

   // Saturation point of the run counter
   localparam logic [COUNT_W-1:0] RUNS_MAX = '1;

   // Q14 sine approximation constants
   localparam int FRAC_W = 14;
   localparam logic [15:0] Q14_ONE = 16'd16384;
   localparam logic [15:0] SIN_C1  = 16'd1160;
   localparam logic [15:0] SIN_C2  = 16'd10512;
   localparam logic [15:0] SIN_C3  = 16'd25736;

   // Register reset values
   localparam logic [15:0] NEAR_THRESHOLD_RESET = 16'd600;
   localparam logic [15:0] START_ANGLE_RESET    = 16'd0;
   localparam logic [15:0] ANGLE_STEP_RESET     = 16'd182;

   // APB address and data
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   typedef enum logic [1:0] {
      REG_NEAR_THRESHOLD = 2'd0,
      REG_START_ANGLE    = 2'd1,
      REG_ANGLE_STEP     = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [RANGE_W-1:0] near_threshold_mm;
      logic [ANGLE_W-1:0] start_angle;
      logic [ANGLE_W-1:0] angle_step;
   } cfg_type;

   // Request from the window tracker to the y evaluator
   typedef struct packed {
      logic               start;
      logic [RANGE_W-1:0] range_mm;
      logic [IDX_W-1:0]   scan_index;
   } y_req_type;

   // Result from the y evaluator
   typedef struct packed {
      logic                    done;
      logic signed [MID_W-1:0] y;
   } y_rsp_type;

   typedef enum logic [3:0] {
      Y_IDLE,
      Y_ANG,
      Y_Z,
      Y_ZZ,
      Y_T1,
      Y_T2,
      Y_S,
      Y_Y,
      Y_FIN
   } y_state_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_CALC,
      CTL_EMIT
   } ctl_state_type;

endpackage

>>> design/lomu_chan_if.sv
`timescale 1ns / 1ps

// Sample channel
interface lomu_req_if import lomu_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] range_mm;
   logic [IDX_W-1:0]   scan_index;
   logic               window_last;

   modport source (output valid, range_mm, scan_index, window_last, input ready);
   modport sink   (input valid, range_mm, scan_index, window_last, output ready);
endinterface

// Result channel
interface lomu_rsp_if import lomu_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [MID_W-1:0] midpoint_mm;
   logic                    obstacle_found;
   logic [COUNT_W-1:0]      run_count;

   modport source (output valid, midpoint_mm, obstacle_found, run_count, input ready);
   modport sink   (input valid, midpoint_mm, obstacle_found, run_count, output ready);
endinterface

>>> design/lidar_obstacle_midpoint_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Transfer when          Carries
// req_chan  in         valid && ready         range_mm, scan_index, window_last
// rsp_chan  out        valid && ready         midpoint_mm, obstacle_found, run_count
// APB       in         psel&penable&pwrite    near_threshold_mm, start_angle, angle_step
//
// A sample that needs no sine is taken with the controller staying idle. One
// that opens the first run or closes a run waits while y runs through eight
// sequencer states, six of them passes through its single multiplier, before y
// is handed back. A window's last sample then loads the result register. Reset
// is synchronous and clears all window state. The input stays ready while a
// result waits; a new result waits for the old.
module lidar_obstacle_midpoint_unit import lomu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   lomu_req_if.sink           req_chan,
   lomu_rsp_if.source         rsp_chan,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   cfg_type   cfg;
   y_req_type y_req;
   y_rsp_type y_rsp;

   ctl_state_type state_ff, state_in;

   logic                    in_run_ff, in_run_in;
   logic [COUNT_W-1:0]      runs_ff, runs_in;
   logic signed [MID_W-1:0] first_ff, first_in;
   logic signed [MID_W-1:0] last_y_ff, last_y_in;
   logic [RANGE_W-1:0]      prev_range_ff, prev_range_in;
   logic [IDX_W-1:0]        prev_idx_ff, prev_idx_in;
   logic                    dst_first_ff, dst_first_in;
   logic                    dst_last_ff, dst_last_in;
   logic                    win_end_ff, win_end_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [MID_W-1:0] mid_ff, mid_in;
   logic                    found_ff, found_in;
   logic [COUNT_W-1:0]      count_ff, count_in;

   logic                    accept;
   logic [IDX_W-1:0]        cur_idx;
   logic                    near;
   logic                    open_run;
   logic                    close_prev;
   logic                    need_first;
   logic                    need_last_cur;
   logic signed [MID_W:0]   y_sum;

   lomu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lomu_yeval u_yeval (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (y_req),
      .rsp   (y_rsp)
   );

   assign req_chan.ready = (state_ff == CTL_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // Run detection on the offered sample
   assign cur_idx       = IDX_W'(req_chan.scan_index % SCAN_POINTS);
   assign near          = req_chan.range_mm < cfg.near_threshold_mm;
   assign open_run      = near && !in_run_ff;
   assign close_prev    = !near && in_run_ff;
   assign need_first    = open_run && (runs_ff == '0);
   assign need_last_cur = req_chan.window_last && near;

   // A run closing on the previous sample and a sine on this one never coincide
   assign y_req.start      = accept && (close_prev || need_first || need_last_cur);
   assign y_req.range_mm   = close_prev ? prev_range_ff : req_chan.range_mm;
   assign y_req.scan_index = close_prev ? prev_idx_ff : cur_idx;

   // Midpoint, floor of the half sum
   assign y_sum = (MID_W+1)'(first_ff) + (MID_W+1)'(last_y_ff);

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.midpoint_mm    = mid_ff;
   assign rsp_chan.obstacle_found = found_ff;
   assign rsp_chan.run_count      = count_ff;

   // Window control
   always_comb begin
      state_in      = state_ff;
      in_run_in     = in_run_ff;
      runs_in       = runs_ff;
      first_in      = first_ff;
      last_y_in     = last_y_ff;
      prev_range_in = prev_range_ff;
      prev_idx_in   = prev_idx_ff;
      dst_first_in  = dst_first_ff;
      dst_last_in   = dst_last_ff;
      win_end_in    = win_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      mid_in        = mid_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               prev_range_in = req_chan.range_mm;
               prev_idx_in   = cur_idx;
               in_run_in     = near;
               if (open_run && (runs_ff != RUNS_MAX)) begin
                  runs_in = runs_ff + 1'b1;
               end
               dst_first_in = !close_prev && need_first;
               dst_last_in  = close_prev || need_last_cur;
               win_end_in   = req_chan.window_last;
               if (y_req.start) begin
                  state_in = CTL_CALC;
               end else if (req_chan.window_last) begin
                  state_in = CTL_EMIT;
               end
            end
         end
         CTL_CALC: begin
            if (y_rsp.done) begin
               if (dst_first_ff) begin
                  first_in = y_rsp.y;
               end
               if (dst_last_ff) begin
                  last_y_in = y_rsp.y;
               end
               state_in = win_end_ff ? CTL_EMIT : CTL_IDLE;
            end
         end
         CTL_EMIT: begin
            // Load the result once the output register is free, then clear
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               found_in      = (runs_ff != '0);
               mid_in        = (runs_ff != '0) ? MID_W'(y_sum >>> 1) : '0;
               count_in      = runs_ff;
               in_run_in     = 1'b0;
               runs_in       = '0;
               first_in      = '0;
               last_y_in     = '0;
               prev_range_in = '0;
               prev_idx_in   = '0;
               state_in      = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CTL_IDLE;
         in_run_ff     <= 1'b0;
         runs_ff       <= '0;
         first_ff      <= '0;
         last_y_ff     <= '0;
         prev_range_ff <= '0;
         prev_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_run_ff     <= in_run_in;
         runs_ff       <= runs_in;
         first_ff      <= first_in;
         last_y_ff     <= last_y_in;
         prev_range_ff <= prev_range_in;
         prev_idx_ff   <= prev_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Per-item routing and result payload
   always_ff @(posedge clock) begin
      dst_first_ff <= dst_first_in;
      dst_last_ff  <= dst_last_in;
      win_end_ff   <= win_end_in;
      mid_ff       <= mid_in;
      found_ff     <= found_in;
      count_ff     <= count_in;
   end

endmodule

>>> design/lomu_csr.sv
`timescale 1ns / 1ps

module lomu_csr import lomu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel = reg_index_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_NEAR_THRESHOLD: cfg_in.near_threshold_mm = pwdata[RANGE_W-1:0];
            REG_START_ANGLE:    cfg_in.start_angle       = pwdata[ANGLE_W-1:0];
            REG_ANGLE_STEP:     cfg_in.angle_step        = pwdata[ANGLE_W-1:0];
            default:            cfg_in                   = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_threshold_mm <= NEAR_THRESHOLD_RESET;
         cfg_ff.start_angle       <= START_ANGLE_RESET;
         cfg_ff.angle_step        <= ANGLE_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_sel)
         REG_NEAR_THRESHOLD: prdata = PDATA_W'(cfg_ff.near_threshold_mm);
         REG_START_ANGLE:    prdata = PDATA_W'(cfg_ff.start_angle);
         REG_ANGLE_STEP:     prdata = PDATA_W'(cfg_ff.angle_step);
         default:            prdata = '0;
      endcase
   end

endmodule

>>> design/lomu_yeval.sv
`timescale 1ns / 1ps

// y = range * sin(start_angle + angle_step * index), one shared 16x16 multiplier
// stepped by a small sequencer; the product is registered after every pass.
module lomu_yeval import lomu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  y_req_type req,
   output y_rsp_type rsp
);

   y_state_type state_ff, state_in;

   logic [RANGE_W-1:0]      range_ff, range_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [1:0]              quad_ff, quad_in;
   logic [14:0]             z_ff, z_in;
   logic [14:0]             z2_ff, z2_in;
   logic signed [MID_W-1:0] y_ff, y_in;
   logic                    done_ff, done_in;

   logic [15:0]        op_a;
   logic [15:0]        op_b;
   logic [ANGLE_W-1:0] angle;
   logic [15:0]        prod_q;
   logic [15:0]        t_val;
   logic [15:0]        s_val;

   // Shared multiplier
   assign prod_in = op_a * op_b;

   // Last product shifted right by FRAC_W bits, back to Q14 scale
   assign prod_q = prod_ff[FRAC_W +: 16];

   assign rsp.done = done_ff;
   assign rsp.y    = y_ff;

   // Sequencer and operand selection
   always_comb begin
      state_in = state_ff;
      range_in = range_ff;
      idx_in   = idx_ff;
      quad_in  = quad_ff;
      z_in     = z_ff;
      z2_in    = z2_ff;
      y_in     = y_ff;
      done_in  = 1'b0;
      op_a     = '0;
      op_b     = '0;
      angle    = cfg.start_angle + prod_ff[ANGLE_W-1:0];
      t_val    = '0;
      s_val    = '0;
      case (state_ff)
         Y_IDLE: begin
            if (req.start) begin
               range_in = req.range_mm;
               idx_in   = req.scan_index;
               state_in = Y_ANG;
            end
         end
         Y_ANG: begin
            op_a     = cfg.angle_step;
            op_b     = 16'(idx_ff);
            state_in = Y_Z;
         end
         Y_Z: begin
            // Fold the angle into the first quadrant
            quad_in = angle[15:14];
            if (angle[14]) begin
               z_in = 15'(Q14_ONE) - {1'b0, angle[13:0]};
            end else begin
               z_in = {1'b0, angle[13:0]};
            end
            state_in = Y_ZZ;
         end
         Y_ZZ: begin
            op_a     = 16'(z_ff);
            op_b     = 16'(z_ff);
            state_in = Y_T1;
         end
         Y_T1: begin
            z2_in    = prod_ff[FRAC_W +: 15];
            op_a     = SIN_C1;
            op_b     = 16'(prod_ff[FRAC_W +: 15]);
            state_in = Y_T2;
         end
         Y_T2: begin
            t_val    = SIN_C2 - prod_q;
            op_a     = t_val;
            op_b     = 16'(z2_ff);
            state_in = Y_S;
         end
         Y_S: begin
            t_val    = SIN_C3 - prod_q;
            op_a     = t_val;
            op_b     = 16'(z_ff);
            state_in = Y_Y;
         end
         Y_Y: begin
            // Clamp the sine magnitude to one
            s_val    = (prod_q > Q14_ONE) ? Q14_ONE : prod_q;
            op_a     = range_ff;
            op_b     = s_val;
            state_in = Y_FIN;
         end
         Y_FIN: begin
            if (quad_ff[1]) begin
               y_in = -$signed({1'b0, prod_q});
            end else begin
               y_in = $signed({1'b0, prod_q});
            end
            done_in  = 1'b1;
            state_in = Y_IDLE;
         end
         default: state_in = Y_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Y_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      range_ff <= range_in;
      idx_ff   <= idx_in;
      prod_ff  <= prod_in;
      quad_ff  <= quad_in;
      z_ff     <= z_in;
      z2_ff    <= z2_in;
      y_ff     <= y_in;
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lomu_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_PCT      = 26;
   localparam int RUN_CAP       = 1023;
   localparam int LONG_WINDOW   = 200;
   localparam int PHASE_ITEMS   = 140;
   // Address slot past the last register; writes there must be dropped
   localparam logic [1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic [RANGE_W-1:0] range_mm;
      logic [IDX_W-1:0]   scan_index;
      logic               window_last;
   } lidar_sample_type;

   typedef struct packed {
      logic signed [MID_W-1:0] midpoint_mm;
      logic                    obstacle_found;
      logic [COUNT_W-1:0]      run_count;
   } midpoint_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // APB-style register port
   logic               psel    = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite  = 1'b0;
   logic [PADDR_W-1:0] paddr   = '0;
   logic [PDATA_W-1:0] pwdata  = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   // Driven copies of the channel controls
   logic             drv_valid  = 1'b0;
   lidar_sample_type drv_sample = '0;
   logic             mon_ready  = 1'b0;

   lidar_sample_type    sample_q[$];
   midpoint_report_type midpoint_q[$];

   int cycle_count      = 0;
   int errors           = 0;
   int samples_sent     = 0;
   int windows_checked  = 0;
   int settings_written = 0;

   // Predictor configuration and window state
   logic [RANGE_W-1:0] thr_cfg  = NEAR_THRESHOLD_RESET;
   logic [ANGLE_W-1:0] ang0_cfg = START_ANGLE_RESET;
   logic [ANGLE_W-1:0] step_cfg = ANGLE_STEP_RESET;
   bit                 near_run_open = 1'b0;
   int                 run_tally     = 0;
   int                 start_y       = 0;
   int                 end_y         = 0;
   logic [RANGE_W-1:0] prev_range    = '0;
   logic [IDX_W-1:0]   prev_idx      = '0;

   lomu_req_if req_if ();
   lomu_rsp_if rsp_if ();

   assign req_if.valid       = drv_valid;
   assign req_if.range_mm    = drv_sample.range_mm;
   assign req_if.scan_index  = drv_sample.scan_index;
   assign req_if.window_last = drv_sample.window_last;
   assign rsp_if.ready       = mon_ready;

   lidar_obstacle_midpoint_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Q14 sine magnitude: quadrant folding then odd polynomial, clamped to one
   function automatic logic [31:0] sine_mag_q14(input logic [ANGLE_W-1:0] ang);
      logic [31:0] z, z2, t, s;
      z = {18'd0, ang[13:0]};
      if (ang[14]) z = 32'd16384 - z;
      z2 = (z * z) >> 14;
      t  = 32'd10512 - ((32'd1160 * z2) >> 14);
      t  = 32'd25736 - ((t * z2) >> 14);
      s  = (t * z) >> 14;
      if (s > 32'd16384) s = 32'd16384;
      return s;
   endfunction

   // y = range * sin(start + step * index), magnitude truncated toward zero
   function automatic int lateral_y(input logic [RANGE_W-1:0] rng,
                                    input logic [IDX_W-1:0] idx);
      logic [ANGLE_W-1:0] ang;
      logic [31:0]        mag;
      ang = ang0_cfg + step_cfg * idx;
      mag = ({16'd0, rng} * sine_mag_q14(ang)) >> 14;
      return ang[15] ? -int'(mag) : int'(mag);
   endfunction

   // Advance the run tracker by one sample; returns 1 when a report is due
   function automatic bit track_sample(input lidar_sample_type s,
                                       output midpoint_report_type r);
      bit near;
      int sum;
      int mid;
      near = s.range_mm < thr_cfg;
      r = '0;
      if (near) begin
         if (!near_run_open) begin
            near_run_open = 1'b1;
            if (run_tally < RUN_CAP) run_tally++;
            if (run_tally == 1) start_y = lateral_y(s.range_mm, s.scan_index);
         end
      end else if (near_run_open) begin
         end_y = lateral_y(prev_range, prev_idx);
         near_run_open = 1'b0;
      end
      prev_range = s.range_mm;
      prev_idx   = s.scan_index;
      if (!s.window_last) return 1'b0;

      // run still open at the window end closes on this sample
      if (near_run_open) end_y = lateral_y(s.range_mm, s.scan_index);
      if (run_tally > 0) begin
         sum = start_y + end_y;
         mid = sum >>> 1;
      end else begin
         mid = 0;
      end
      r.midpoint_mm    = mid[MID_W-1:0];
      r.obstacle_found = run_tally > 0;
      r.run_count      = run_tally[COUNT_W-1:0];
      near_run_open = 1'b0;
      run_tally     = 0;
      start_y       = 0;
      end_y         = 0;
      prev_range    = '0;
      prev_idx      = '0;
      return 1'b1;
   endfunction

   // Random idling, switched off for the last quarter of every period of the cycle count
   function automatic bit idle_now();
      if ((cycle_count % 6000) >= 4500) return 1'b0;
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   function automatic logic [RANGE_W-1:0] pick_range(input bit near);
      if (near && thr_cfg != 0) return RANGE_W'($urandom_range(0, thr_cfg - 1));
      return RANGE_W'($urandom_range(thr_cfg, 16'hFFFF));
   endfunction

   // Register write: setup cycle then access cycle
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      logic [PDATA_W-1:0] word;
      word = ($urandom() & 32'hFFFF_0000) | {16'd0, val};
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_NEAR_THRESHOLD: thr_cfg  = val;
         REG_START_ANGLE:    ang0_cfg = val;
         REG_ANGLE_STEP:     step_cfg = val;
         default: ;
      endcase
   endtask

   task automatic write_cfg(input logic [15:0] thr, input logic [15:0] a0,
                            input logic [15:0] step);
      write_csr(REG_NEAR_THRESHOLD, thr);
      write_csr(REG_START_ANGLE, a0);
      write_csr(REG_ANGLE_STEP, step);
      settings_written++;
   endtask

   task automatic queue_sample(input logic [RANGE_W-1:0] rng,
                               input logic [IDX_W-1:0] idx, input logic last);
      lidar_sample_type s;
      s.range_mm    = rng;
      s.scan_index  = idx;
      s.window_last = last;
      sample_q.insert(sample_q.size(), s);
   endtask

   // One window: mostly consecutive indexes with near/far runs, sometimes noise
   task automatic queue_window(input int len, input bit noisy);
      lidar_sample_type s;
      logic [IDX_W-1:0] idx;
      bit               near;
      int               k;
      idx  = IDX_W'($urandom_range(0, SCAN_POINTS - 1));
      near = 1'($urandom_range(0, 1));
      for (k = 0; k < len; k++) begin
         if (noisy) begin
            s.range_mm    = RANGE_W'($urandom());
            s.scan_index  = IDX_W'($urandom());
            s.window_last = ($urandom_range(0, 7) == 0);
         end else begin
            if ($urandom_range(0, 99) < 30) near = !near;
            s.range_mm    = pick_range(near);
            s.scan_index  = idx;
            s.window_last = 1'b0;
            idx = idx + 1'b1;
         end
         if (k == len - 1) s.window_last = 1'b1;
         sample_q.insert(sample_q.size(), s);
      end
   endtask

   // Let the sender run dry, collect every report, then let the block settle
   task automatic wait_idle();
      while (sample_q.size() != 0 || drv_valid) @(posedge clock);
      while (midpoint_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sample driver: predict on each transfer, then offer the next sample
   always @(posedge clock) begin
      midpoint_report_type rep;
      lidar_sample_type    nxt;
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_if.ready) begin
            samples_sent++;
            if (track_sample(drv_sample, rep)) midpoint_q.insert(midpoint_q.size(), rep);
         end
         if (!drv_valid || req_if.ready) begin
            if (sample_q.size() != 0 && !idle_now()) begin
               nxt = sample_q.pop_front();
               drv_sample <= nxt;
               drv_valid  <= 1'b1;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // Report monitor: compare each transfer with the oldest prediction
   always @(posedge clock) begin
      midpoint_report_type want;
      if (reset) begin
         mon_ready <= 1'b0;
      end else begin
         if (rsp_if.valid && mon_ready) begin
            if (midpoint_q.size() == 0) begin
               $error("report with nothing predicted: midpoint_mm %0d run_count %0d",
                      $signed(rsp_if.midpoint_mm), rsp_if.run_count);
               errors++;
            end else begin
               want = midpoint_q.pop_front();
               windows_checked++;
               if (rsp_if.midpoint_mm !== want.midpoint_mm) begin
                  $error("midpoint_mm: expected %0d, got %0d",
                         $signed(want.midpoint_mm), $signed(rsp_if.midpoint_mm));
                  errors++;
               end
               if (rsp_if.obstacle_found !== want.obstacle_found) begin
                  $error("obstacle_found: expected %0d, got %0d",
                         want.obstacle_found, rsp_if.obstacle_found);
                  errors++;
               end
               if (rsp_if.run_count !== want.run_count) begin
                  $error("run_count: expected %0d, got %0d",
                         want.run_count, rsp_if.run_count);
                  errors++;
               end
            end
         end
         mon_ready <= !idle_now();
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lidar_obstacle_midpoint_unit: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int p;
      int k;
      int queued;
      int len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed windows at the reset settings
      queue_sample(16'd700, 10'd0, 1'b1);      // lone far sample: nothing found
      queue_sample(16'd0, 10'd1023, 1'b1);     // lone near sample opens and closes
      queue_sample(16'hFFFF, 10'd5, 1'b0);     // run left open at window end
      queue_sample(16'd100, 10'd6, 1'b0);
      queue_sample(16'd200, 10'd7, 1'b0);
      queue_sample(16'd599, 10'd8, 1'b1);
      queue_sample(16'd10, 10'd100, 1'b0);     // run closed by a sample at threshold
      queue_sample(16'd20, 10'd101, 1'b0);
      queue_sample(16'd600, 10'd102, 1'b0);
      queue_sample(16'hFFFF, 10'd103, 1'b1);
      queue_sample(16'd300, 10'd500, 1'b0);    // three runs
      queue_sample(16'd900, 10'd501, 1'b0);
      queue_sample(16'd300, 10'd502, 1'b0);
      queue_sample(16'd900, 10'd503, 1'b0);
      queue_sample(16'd1, 10'd504, 1'b0);
      queue_sample(16'd2, 10'd505, 1'b1);
      queue_sample(16'd599, 10'd0, 1'b0);
      queue_sample(16'd599, 10'd1023, 1'b1);
      queue_sample(16'd50, 10'd900, 1'b0);     // out-of-order index
      queue_sample(16'd60, 10'd10, 1'b1);
      wait_idle();

      // Random phases over a spread of settings, extremes first
      for (p = 0; p < 6; p++) begin
         case (p)
            0: write_cfg(16'd0, 16'($urandom()), 16'($urandom()));
            1: write_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: write_cfg(16'($urandom_range(200, 8000)),
                         16'(16384 * $urandom_range(0, 3)), 16'd0);
            3: begin
               write_cfg(16'($urandom()), 16'($urandom()), 16'($urandom()));
               write_csr(REG_SPARE, 16'($urandom()));
            end
            default: write_cfg(16'($urandom()), 16'($urandom()), 16'($urandom()));
         endcase
         queued = 0;
         while (queued < PHASE_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                               : $urandom_range(1, 16);
            queue_window(len, $urandom_range(0, 7) == 0);
            queued += len;
         end
         wait_idle();
      end

      // Long alternating near/far window: a hundred runs in one window
      write_cfg(16'd1, 16'($urandom()), ANGLE_STEP_RESET);
      for (k = 0; k < LONG_WINDOW; k++)
         queue_sample(k[0] ? 16'hFFFF : 16'd0, k[IDX_W-1:0], k == LONG_WINDOW - 1);
      queue_window(6, 1'b0);
      wait_idle();

      if (midpoint_q.size() != 0) begin
         $error("%0d predicted reports never arrived", midpoint_q.size());
         errors++;
      end
      $display("covered %0d samples and %0d window reports over %0d register settings",
               samples_sent, windows_checked, settings_written);
      $display("including open runs at window end, noise windows and a many-run window");
      if (errors == 0) begin
         $display("lidar_obstacle_midpoint_unit: match");
      end else begin
         $display("lidar_obstacle_midpoint_unit: mismatch");
      end
      $finish;
   end

endmodule

>>> lidar_obstacle_midpoint_unit.f
design/lomu_pkg.sv
design/lomu_chan_if.sv
design/lomu_csr.sv
design/lomu_yeval.sv
design/lidar_obstacle_midpoint_unit.sv
test/tb_top.sv
